// File: rtl/mktd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mktd_pkg
// Shared types, constants and the Morse character table for the Morse key
// timing decoder.
// ----------------------------------------------------------------------------
package mktd_pkg;

  localparam int unsigned TimeW    = 16;
  localparam int unsigned CharW    = 8;
  localparam int unsigned LenW     = 3;
  localparam int unsigned OvfW     = 2;
  localparam int unsigned CodeW    = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned RomIdxW  = 6;

  localparam logic [CodeW-1:0] CodeZero    = '0;
  localparam logic [LenW-1:0]  MaxSymbols  = 3'd5;
  localparam logic [LenW-1:0]  MaxCount    = 3'd7;
  localparam logic [OvfW-1:0]  OvfSat      = 2'd2;
  localparam logic [CharW-1:0] CharUnknown = 8'h25;

  localparam logic [TimeW-1:0] DotMinReset    = 16'd1875;
  localparam logic [TimeW-1:0] DashMinReset   = 16'd12500;
  localparam logic [TimeW-1:0] SpaceMinReset  = 16'd25000;
  localparam logic [TimeW-1:0] LongIntvReset  = 16'd30000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDotMin   = 2'd0,
    CfgDashMin  = 2'd1,
    CfgSpaceMin = 2'd2,
    CfgLongIntv = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ModeTick = 1'b0,
    ModeEdge = 1'b1
  } mode_e;

  typedef struct packed {
    logic [TimeW-1:0] dot_min;
    logic [TimeW-1:0] dash_min;
    logic [TimeW-1:0] space_min;
    logic [TimeW-1:0] long_intv;
  } cfg_t;

  typedef struct packed {
    logic             awaiting_press;
    logic [TimeW-1:0] last_edge_time;
    logic [OvfW-1:0]  overflow_count;
    logic [CodeW-1:0] code_bits;
    logic [LenW-1:0]  code_count;
  } state_t;

  typedef struct packed {
    logic             emit;
    logic [CharW-1:0] character;
    logic [LenW-1:0]  code_length;
  } result_t;

  function automatic logic [CharW-1:0] morse_char(input logic [RomIdxW-1:0] idx);
    logic [CharW-1:0] c;
    unique case (idx)
      6'd1:  c = 8'h20;
      6'd2:  c = "E";
      6'd3:  c = "T";
      6'd4:  c = "I";
      6'd5:  c = "A";
      6'd6:  c = "N";
      6'd7:  c = "M";
      6'd8:  c = "S";
      6'd9:  c = "U";
      6'd10: c = "R";
      6'd11: c = "W";
      6'd12: c = "D";
      6'd13: c = "K";
      6'd14: c = "G";
      6'd15: c = "O";
      6'd16: c = "H";
      6'd17: c = "V";
      6'd18: c = "F";
      6'd20: c = "L";
      6'd22: c = "P";
      6'd23: c = "J";
      6'd24: c = "B";
      6'd25: c = "X";
      6'd26: c = "C";
      6'd27: c = "Y";
      6'd28: c = "Z";
      6'd29: c = "Q";
      6'd30: c = "?";
      6'd31: c = "&";
      6'd32: c = "5";
      6'd33: c = "4";
      6'd35: c = "3";
      6'd39: c = "2";
      6'd47: c = "1";
      6'd48: c = "6";
      6'd56: c = "7";
      6'd60: c = "8";
      6'd62: c = "9";
      6'd63: c = "0";
      default: c = CharUnknown;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/mktd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mktd_if
// Valid/ready channels of the Morse key timing decoder: event input, decoded
// character output and register write port.
// ----------------------------------------------------------------------------
interface mktd_in_if import mktd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [TimeW-1:0] capture_time;

  modport source (output valid, output mode, output capture_time, input ready);
  modport sink   (input valid, input mode, input capture_time, output ready);
endinterface

interface mktd_out_if import mktd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] character;
  logic [LenW-1:0]  code_length;

  modport source (output valid, output character, output code_length, input ready);
  modport sink   (input valid, input character, input code_length, output ready);
endinterface

interface mktd_cfg_if import mktd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [TimeW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/mktd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mktd_decode
// Per-event update: interval measurement, press classification, symbol
// shift-in and character lookup at the end of a gap.
// ----------------------------------------------------------------------------
module mktd_decode import mktd_pkg::*; (
  input  cfg_t             cfg_i,
  input  state_t           state_i,
  input  logic             mode_i,
  input  logic [TimeW-1:0] capture_time_i,
  output state_t           state_o,
  output result_t          result_o
);

  logic [TimeW-1:0]   diff;
  logic [TimeW-1:0]   interval;
  logic [RomIdxW-1:0] rom_idx;
  logic [CharW-1:0]   char_val;
  logic               is_dot;
  logic               is_dash;

  // wrapped interval is 65535 + now - last, i.e. one less than the modular difference
  assign diff = capture_time_i - state_i.last_edge_time;

  always_comb begin
    priority if (state_i.overflow_count > 2'd1) begin
      interval = cfg_i.long_intv;
    end else if (capture_time_i < state_i.last_edge_time) begin
      interval = diff - 16'd1;
    end else begin
      interval = diff;
    end
  end

  assign is_dot  = (interval >= cfg_i.dot_min) && (interval <= cfg_i.dash_min);
  assign is_dash = interval > cfg_i.dash_min;

  assign rom_idx  = (RomIdxW'(1) << state_i.code_count) | {1'b0, state_i.code_bits};
  assign char_val = (state_i.code_count > MaxSymbols) ? CharUnknown : morse_char(rom_idx);

  always_comb begin
    state_o              = state_i;
    result_o.emit        = 1'b0;
    result_o.character   = char_val;
    result_o.code_length = state_i.code_count;
    unique case (mode_e'(mode_i))
      ModeTick: begin
        if (state_i.overflow_count < OvfSat) begin
          state_o.overflow_count = state_i.overflow_count + 2'd1;
        end
      end
      ModeEdge: begin
        state_o.overflow_count = '0;
        state_o.last_edge_time = capture_time_i;
        if (state_i.awaiting_press) begin
          state_o.awaiting_press = 1'b0;
          if (interval >= cfg_i.space_min) begin
            result_o.emit     = 1'b1;
            state_o.code_bits  = CodeZero;
            state_o.code_count = '0;
          end
        end else begin
          state_o.awaiting_press = 1'b1;
          if (is_dot || is_dash) begin
            if (state_i.code_count < MaxSymbols) begin
              state_o.code_bits = {state_i.code_bits[CodeW-2:0], is_dash};
            end
            if (state_i.code_count < MaxCount) begin
              state_o.code_count = state_i.code_count + 3'd1;
            end
          end
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

// File: rtl/morse_key_timing_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_key_timing_decoder_core
// Morse key timing decoder: turns timer ticks and key edge captures into
// decoded characters.
// ----------------------------------------------------------------------------
// datapath: the input register feeds the update, and the result register
//   holds the word
// throughput: one event per cycle; an edge that ends a character waits while
//   the result register is full
// reset: rst_ni asynchronous, clears decoder state and loads default timing
// ----------------------------------------------------------------------------
module morse_key_timing_decoder_core import mktd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  mktd_in_if.sink      in_i,
  mktd_out_if.source   out_o,
  mktd_cfg_if.sink     cfg_i
);

  cfg_t             cfg_q;
  state_t           state_q;
  state_t           state_d;
  result_t          result;

  logic             in_valid_q;
  logic             in_mode_q;
  logic [TimeW-1:0] in_time_q;

  logic             out_valid_q;
  logic [CharW-1:0] out_char_q;
  logic [LenW-1:0]  out_len_q;

  logic             out_free;
  logic             advance;

  mktd_decode u_decode (
    .cfg_i          (cfg_q),
    .state_i        (state_q),
    .mode_i         (in_mode_q),
    .capture_time_i (in_time_q),
    .state_o        (state_d),
    .result_o       (result)
  );

  assign out_free    = !out_valid_q || out_o.ready;
  assign advance     = in_valid_q && (!result.emit || out_free);
  assign in_i.ready  = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid       = out_valid_q;
  assign out_o.character   = out_char_q;
  assign out_o.code_length = out_len_q;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dot_min   <= DotMinReset;
      cfg_q.dash_min  <= DashMinReset;
      cfg_q.space_min <= SpaceMinReset;
      cfg_q.long_intv <= LongIntvReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CfgDotMin:   cfg_q.dot_min   <= cfg_i.data;
        CfgDashMin:  cfg_q.dash_min  <= cfg_i.data;
        CfgSpaceMin: cfg_q.space_min <= cfg_i.data;
        CfgLongIntv: cfg_q.long_intv <= cfg_i.data;
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_mode_q <= in_i.mode;
      in_time_q <= in_i.capture_time;
    end
  end

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.awaiting_press <= 1'b1;
      state_q.last_edge_time <= '0;
      state_q.overflow_count <= '0;
      state_q.code_bits      <= CodeZero;
      state_q.code_count     <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && result.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result.emit) begin
      out_char_q <= result.character;
      out_len_q  <= result.code_length;
    end
  end

endmodule
